[hw/rtl/adc_avg_pkg.sv]
// Shared types and constants for the ADC scan averager.
// No dependencies; compiled first.
package adc_avg_pkg;

    localparam int CODE_W  = 12;
    localparam int SUM_W   = 20;
    localparam int SLOT_W  = 3;
    localparam int KIND_W  = 2;
    localparam int MV_W    = 16;
    localparam int RATE_W  = 20;
    localparam int NSL_W   = 4;
    localparam int CNT8_W  = 8;
    localparam int DVS_W   = 9;        // divisor 1..256
    localparam int REM_W   = DVS_W - 1;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int PROD_W  = CODE_W + RATE_W;

    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [CODE_W-1:0] CODE_MAX = '1;

    // register reset values
    localparam logic [NSL_W-1:0]  RST_NUM_SLOTS  = 4'd3;
    localparam logic [CNT8_W-1:0] RST_FILTER_LEN = 8'd10;
    localparam logic [RATE_W-1:0] RST_MV_RATE    = 20'd38400;
    localparam logic [CNT8_W-1:0] RST_PASS_LIM   = 8'd20;

    // register index, paddr[3:2]
    localparam logic [1:0] REG_NUM_SLOTS  = 2'd0;
    localparam logic [1:0] REG_FILTER_LEN = 2'd1;
    localparam logic [1:0] REG_MV_RATE    = 2'd2;
    localparam logic [1:0] REG_PASS_LIM   = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AVG    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_AVG,
        S_FINAL
    } t_state;

endpackage

[hw/rtl/adc_avg_if.sv]
// Valid/ready channel interfaces for the ADC scan averager.
// Depends on adc_avg_pkg for field widths.
interface adc_avg_smp_if;
    logic                              valid;
    logic                              ready;
    logic [adc_avg_pkg::CODE_W-1:0]    conversion_code;

    modport source (output valid, output conversion_code, input ready);
    modport sink   (input valid, input conversion_code, output ready);
endinterface

interface adc_avg_res_if;
    logic                              valid;
    logic                              ready;
    logic [adc_avg_pkg::KIND_W-1:0]    result_kind;
    logic [adc_avg_pkg::SLOT_W-1:0]    slot;
    logic [adc_avg_pkg::CODE_W-1:0]    average_code;
    logic [adc_avg_pkg::MV_W-1:0]      voltage_mv;
    logic                              last;

    modport source (output valid, output result_kind, output slot, output average_code,
                    output voltage_mv, output last, input ready);
    modport sink   (input valid, input result_kind, input slot, input average_code,
                    input voltage_mv, input last, output ready);
endinterface

[hw/rtl/adc_avg_div.sv]
// Restoring divider, one quotient bit per cycle: sum / round count.
// Depends on adc_avg_pkg.
module adc_avg_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [adc_avg_pkg::SUM_W-1:0]    i_dividend,
    input  logic [adc_avg_pkg::DVS_W-1:0]    i_divisor,
    output logic                             o_done,
    output logic [adc_avg_pkg::SUM_W-1:0]    o_quotient
);
    localparam int CNT_W = $clog2(adc_avg_pkg::SUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(adc_avg_pkg::SUM_W - 1);

    logic                              r_busy;
    logic                              r_done;
    logic [CNT_W-1:0]                  r_cnt;
    logic [adc_avg_pkg::SUM_W-1:0]     r_quo;
    logic [adc_avg_pkg::REM_W-1:0]     r_rem;
    logic [adc_avg_pkg::DVS_W-1:0]     r_dsr;

    logic [adc_avg_pkg::DVS_W-1:0]     trial;
    logic                              ge;
    logic [adc_avg_pkg::REM_W-1:0]     n_rem;

    // remainder stays below the divisor, so trial < 2 * divisor
    always_comb begin
        trial = {r_rem, r_quo[adc_avg_pkg::SUM_W-1]};
        ge    = (trial >= r_dsr);
        n_rem = ge ? adc_avg_pkg::REM_W'(trial - r_dsr) : trial[adc_avg_pkg::REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[adc_avg_pkg::SUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hw/rtl/adc_scan_averager.sv]
// ADC scan averager top level: scan sequencer, slot sums, output register.
// Depends on adc_avg_pkg, adc_avg_if.sv and adc_avg_div.
//
// Usage: i_smp carries one finished 12-bit conversion per transfer for the
// slot now being converted. o_res returns the results it causes: a request
// to start the next slot, per-slot averages at the end of an averaging pass
// (code and millivolts), and a scan-finished marker; last flags the final
// result of each sample. After the finish marker samples are taken and dropped.
// Registers are written over the APB port (num_slots, filter_len,
// mv_per_code_q16, passes_limit at 0x0/0x4/0x8/0xC); the user must write
// them only while idle; the block does not enforce it. An ordinary sample
// yields its single result, registered into the output register on its
// transfer. At a pass end each slot goes through the shared bit-serial
// divider with start and output steps, then a START or FINISH result
// follows; no sample is taken until that result is loaded.
// Reset clears the sums, counters, finish flag and registers to defaults.
// A stalled receiver holds the output register; no result is dropped and
// the sequencer waits with the next result until the register is free.
module adc_scan_averager #(
    parameter int MAX_SLOTS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    adc_avg_smp_if.sink                        i_smp,
    adc_avg_res_if.source                      o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [adc_avg_pkg::ADDR_W-1:0]     paddr,
    input  logic [adc_avg_pkg::DATA_W-1:0]     pwdata,
    output logic [adc_avg_pkg::DATA_W-1:0]     prdata,
    output logic                               pready
);
    localparam int SLOT_IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int WALK_W  = $clog2(MAX_SLOTS + 1);

    // configuration
    logic [adc_avg_pkg::NSL_W-1:0]   r_num_slots;
    logic [adc_avg_pkg::CNT8_W-1:0]  r_filter_len;
    logic [adc_avg_pkg::RATE_W-1:0]  r_mv_rate;
    logic [adc_avg_pkg::CNT8_W-1:0]  r_pass_lim;

    // scan state
    adc_avg_pkg::t_state             r_state, n_state;
    logic [adc_avg_pkg::SLOT_W-1:0]  r_cs;
    logic [adc_avg_pkg::CNT8_W-1:0]  r_rc;
    logic [adc_avg_pkg::CNT8_W-1:0]  r_pc;
    logic                            r_fin;
    logic [WALK_W-1:0]               r_walk;
    logic [adc_avg_pkg::DVS_W-1:0]   r_dvs;
    logic [adc_avg_pkg::CODE_W-1:0]  r_avg;
    logic [adc_avg_pkg::SUM_W-1:0]   r_sum [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]            r_sum_vld;

    // output register
    logic                            r_ov;
    logic [adc_avg_pkg::KIND_W-1:0]  r_kind;
    logic [adc_avg_pkg::SLOT_W-1:0]  r_slot;
    logic [adc_avg_pkg::CODE_W-1:0]  r_avgo;
    logic [adc_avg_pkg::MV_W-1:0]    r_mv;
    logic                            r_last;

    logic [adc_avg_pkg::KIND_W-1:0]  n_kind;
    logic [adc_avg_pkg::SLOT_W-1:0]  n_slot;
    logic [adc_avg_pkg::CODE_W-1:0]  n_avgo;
    logic [adc_avg_pkg::MV_W-1:0]    n_mv;

    logic                            out_free;
    logic                            smp_ready;
    logic                            acc;
    logic                            take;
    logic                            ld_out;
    logic                            div_start;
    logic                            clr_sums;
    logic                            set_fin;
    logic                            div_done;
    logic [adc_avg_pkg::SUM_W-1:0]   div_quo;

    logic [WALK_W-1:0]               slots_eff;
    logic [adc_avg_pkg::CNT8_W-1:0]  flen_eff;
    logic [adc_avg_pkg::CNT8_W-1:0]  plim_eff;
    logic [adc_avg_pkg::SLOT_W-1:0]  cs1;
    logic [adc_avg_pkg::CNT8_W-1:0]  rc1;
    logic                            mid_round;
    logic                            pass_end;
    logic                            lim_hit;
    logic                            cs_in_tab;
    logic [SLOT_IW-1:0]              acc_idx;
    logic [SLOT_IW-1:0]              walk_idx;
    logic [adc_avg_pkg::SUM_W-1:0]   acc_old;
    logic [adc_avg_pkg::SUM_W:0]     acc_add;
    logic [adc_avg_pkg::SUM_W-1:0]   walk_sum;
    logic [adc_avg_pkg::PROD_W-1:0]  prod;
    logic                            walk_end;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_slots  <= adc_avg_pkg::RST_NUM_SLOTS;
            r_filter_len <= adc_avg_pkg::RST_FILTER_LEN;
            r_mv_rate    <= adc_avg_pkg::RST_MV_RATE;
            r_pass_lim   <= adc_avg_pkg::RST_PASS_LIM;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                adc_avg_pkg::REG_NUM_SLOTS:
                    r_num_slots  <= pwdata[adc_avg_pkg::NSL_W-1:0];
                adc_avg_pkg::REG_FILTER_LEN:
                    r_filter_len <= pwdata[adc_avg_pkg::CNT8_W-1:0];
                adc_avg_pkg::REG_MV_RATE:
                    r_mv_rate    <= pwdata[adc_avg_pkg::RATE_W-1:0];
                adc_avg_pkg::REG_PASS_LIM:
                    r_pass_lim   <= pwdata[adc_avg_pkg::CNT8_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            adc_avg_pkg::REG_NUM_SLOTS:  prdata = adc_avg_pkg::DATA_W'(r_num_slots);
            adc_avg_pkg::REG_FILTER_LEN: prdata = adc_avg_pkg::DATA_W'(r_filter_len);
            adc_avg_pkg::REG_MV_RATE:    prdata = adc_avg_pkg::DATA_W'(r_mv_rate);
            adc_avg_pkg::REG_PASS_LIM:   prdata = adc_avg_pkg::DATA_W'(r_pass_lim);
            default:                     prdata = '0;
        endcase
    end

    // ---------------- scan decode ----------------
    always_comb begin
        if (r_num_slots == '0)
            slots_eff = WALK_W'(1);
        else if (int'(r_num_slots) > MAX_SLOTS)
            slots_eff = WALK_W'(MAX_SLOTS);
        else
            slots_eff = WALK_W'(r_num_slots);
        flen_eff  = (r_filter_len == '0) ? 8'd1 : r_filter_len;
        plim_eff  = (r_pass_lim == '0) ? 8'd1 : r_pass_lim;
        cs1       = r_cs + 1'b1;
        rc1       = r_rc + 1'b1;
        mid_round = (cs1 != '0) && (int'(cs1) < int'(slots_eff));
        pass_end  = (rc1 >= flen_eff) || (rc1 == '0);
        lim_hit   = (r_pc >= plim_eff);
        cs_in_tab = (int'(r_cs) < MAX_SLOTS);
        acc_idx   = SLOT_IW'(r_cs);
        walk_idx  = r_walk[SLOT_IW-1:0];
        acc_old   = r_sum_vld[acc_idx] ? r_sum[acc_idx] : '0;
        acc_add   = {1'b0, acc_old} + (adc_avg_pkg::SUM_W + 1)'(i_smp.conversion_code);
        walk_sum  = r_sum_vld[walk_idx] ? r_sum[walk_idx] : '0;
        prod      = r_avg * r_mv_rate;
        walk_end  = ((r_walk + 1'b1) == slots_eff);
    end

    assign out_free = !r_ov || o_res.ready;
    assign acc      = i_smp.valid && smp_ready;
    assign take     = acc && !r_fin;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            adc_avg_pkg::S_IDLE:
                if (take && !mid_round && pass_end) n_state = adc_avg_pkg::S_START;
            adc_avg_pkg::S_START:
                n_state = adc_avg_pkg::S_WAIT;
            adc_avg_pkg::S_WAIT:
                if (div_done) n_state = adc_avg_pkg::S_AVG;
            adc_avg_pkg::S_AVG:
                if (out_free) n_state = walk_end ? adc_avg_pkg::S_FINAL : adc_avg_pkg::S_START;
            adc_avg_pkg::S_FINAL:
                if (out_free) n_state = adc_avg_pkg::S_IDLE;
            default:
                n_state = adc_avg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        smp_ready = 1'b0;
        div_start = 1'b0;
        ld_out    = 1'b0;
        clr_sums  = 1'b0;
        set_fin   = 1'b0;
        n_kind    = adc_avg_pkg::KIND_START;
        n_slot    = '0;
        n_avgo    = '0;
        n_mv      = '0;
        case (r_state)
            adc_avg_pkg::S_IDLE: begin
                smp_ready = out_free;
                if (take && mid_round) begin
                    ld_out = 1'b1;
                    n_slot = cs1;
                end else if (take && !pass_end) begin
                    ld_out  = 1'b1;
                    set_fin = lim_hit;
                    n_kind  = lim_hit ? adc_avg_pkg::KIND_FINISH : adc_avg_pkg::KIND_START;
                end
            end
            adc_avg_pkg::S_START:
                div_start = 1'b1;
            adc_avg_pkg::S_WAIT: ;
            adc_avg_pkg::S_AVG: begin
                ld_out = out_free;
                n_kind = adc_avg_pkg::KIND_AVG;
                n_slot = adc_avg_pkg::SLOT_W'(r_walk);
                n_avgo = r_avg;
                n_mv   = prod[adc_avg_pkg::PROD_W-1 -: adc_avg_pkg::MV_W];
            end
            adc_avg_pkg::S_FINAL: begin
                ld_out   = out_free;
                clr_sums = out_free;
                set_fin  = out_free && lim_hit;
                n_kind   = lim_hit ? adc_avg_pkg::KIND_FINISH : adc_avg_pkg::KIND_START;
            end
            default: ;
        endcase
    end

    assign i_smp.ready = smp_ready;

    adc_avg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (walk_sum),
        .i_divisor  (r_dvs),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= adc_avg_pkg::S_IDLE;
            r_cs      <= '0;
            r_rc      <= '0;
            r_pc      <= '0;
            r_fin     <= 1'b0;
            r_walk    <= '0;
            r_sum_vld <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take) begin
                if (cs_in_tab) r_sum_vld[acc_idx] <= 1'b1;
                if (mid_round) begin
                    r_cs <= cs1;
                end else begin
                    r_cs <= '0;
                    if (pass_end) begin
                        r_rc <= '0;
                        if (r_pc != '1) r_pc <= r_pc + 1'b1;
                    end else begin
                        r_rc <= rc1;
                    end
                end
                r_walk <= '0;
            end
            if (r_state == adc_avg_pkg::S_AVG && out_free) r_walk <= r_walk + 1'b1;
            if (clr_sums) r_sum_vld <= '0;
            if (set_fin) r_fin <= 1'b1;
            if (ld_out)
                r_ov <= 1'b1;
            else if (o_res.ready)
                r_ov <= 1'b0;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (take && cs_in_tab)
            r_sum[acc_idx] <= acc_add[adc_avg_pkg::SUM_W] ? adc_avg_pkg::SUM_MAX
                                                            : acc_add[adc_avg_pkg::SUM_W-1:0];
        if (take && !mid_round && pass_end)
            r_dvs <= (rc1 == '0) ? adc_avg_pkg::DVS_W'(256) : adc_avg_pkg::DVS_W'(rc1);
        if (div_done)
            r_avg <= (div_quo[adc_avg_pkg::SUM_W-1:adc_avg_pkg::CODE_W] != '0)
                     ? adc_avg_pkg::CODE_MAX : div_quo[adc_avg_pkg::CODE_W-1:0];
        if (ld_out) begin
            r_kind <= n_kind;
            r_slot <= n_slot;
            r_avgo <= n_avgo;
            r_mv   <= n_mv;
            r_last <= (n_kind != adc_avg_pkg::KIND_AVG);
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.result_kind  = r_kind;
    assign o_res.slot         = r_slot;
    assign o_res.average_code = r_avgo;
    assign o_res.voltage_mv   = r_mv;
    assign o_res.last         = r_last;

    // ---------------- assertions ----------------
    a_fin_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> r_fin)
        else $error("finish flag dropped");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_out |-> out_free)
        else $error("output register overwritten");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == adc_avg_pkg::S_WAIT)
        else $error("divider result outside wait state");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == adc_avg_pkg::S_START || r_state == adc_avg_pkg::S_AVG)
            |-> r_walk < slots_eff)
        else $error("slot walk past table");

endmodule

[verif/adc_scan_averager_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for adc_scan_averager: feeds conversion codes and APB register
// writes, predicts every scan result in a behavioral model and compares field by field.
// Depends on adc_avg_pkg, adc_avg_if.sv and the adc_scan_averager RTL.
module adc_scan_averager_tb;

    localparam int NUM_SLOTS_MAX = 8;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 250;

    typedef struct packed {
        logic [adc_avg_pkg::KIND_W-1:0] kind;
        logic [adc_avg_pkg::SLOT_W-1:0] slot;
        logic [adc_avg_pkg::CODE_W-1:0] avg_code;
        logic [adc_avg_pkg::MV_W-1:0]   mv;
        logic                           last;
    } t_scan_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [adc_avg_pkg::ADDR_W-1:0] paddr;
    logic [adc_avg_pkg::DATA_W-1:0] pwdata;
    logic [adc_avg_pkg::DATA_W-1:0] prdata;
    logic                           pready;

    adc_avg_smp_if smp_bus ();
    adc_avg_res_if res_bus ();

    adc_scan_averager uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // scan model: registers and state
    logic [adc_avg_pkg::NSL_W-1:0]  reg_slots;
    logic [adc_avg_pkg::CNT8_W-1:0] reg_flen;
    logic [adc_avg_pkg::RATE_W-1:0] reg_rate;
    logic [adc_avg_pkg::CNT8_W-1:0] reg_plim;
    logic [adc_avg_pkg::SLOT_W-1:0] scan_slot;
    logic [adc_avg_pkg::SUM_W-1:0]  slot_sums [NUM_SLOTS_MAX];
    logic [adc_avg_pkg::CNT8_W-1:0] round_cnt;
    logic [adc_avg_pkg::CNT8_W-1:0] pass_cnt;
    logic                           scan_done;

    logic [adc_avg_pkg::CODE_W-1:0] sample_codes [$];
    t_scan_result                   due_results [$];

    int errors = 0;
    int cycles = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    always #5 i_clk = ~i_clk;

    function automatic void add_result(input logic [adc_avg_pkg::KIND_W-1:0] kind,
                                       input int unsigned slot,
                                       input int unsigned avg, input int unsigned mv,
                                       input logic last);
        t_scan_result r;
        r.kind     = kind;
        r.slot     = adc_avg_pkg::SLOT_W'(slot);
        r.avg_code = adc_avg_pkg::CODE_W'(avg);
        r.mv       = adc_avg_pkg::MV_W'(mv);
        r.last     = last;
        due_results.push_back(r);
    endfunction

    function automatic void predict_scan_step(input logic [adc_avg_pkg::CODE_W-1:0] code);
        int unsigned     n;
        int unsigned     flen;
        int unsigned     plim;
        int unsigned     divisor;
        int unsigned     acc;
        int unsigned     avg;
        longint unsigned mv;
        if (scan_done)
            return;
        n    = reg_slots;
        flen = (reg_flen == 0) ? 1 : reg_flen;
        plim = (reg_plim == 0) ? 1 : reg_plim;
        if (n == 0)
            n = 1;
        if (n > NUM_SLOTS_MAX)
            n = NUM_SLOTS_MAX;

        acc = slot_sums[scan_slot] + code;
        slot_sums[scan_slot] = (acc > adc_avg_pkg::SUM_MAX) ? adc_avg_pkg::SUM_MAX
                                                             : adc_avg_pkg::SUM_W'(acc);
        scan_slot = scan_slot + 1'b1;

        if (scan_slot != 0 && scan_slot < n) begin
            add_result(adc_avg_pkg::KIND_START, scan_slot, 0, 0, 1'b1);
            return;
        end

        // round end, also taken at once when the table shrank below the current slot
        scan_slot = '0;
        round_cnt = round_cnt + 1'b1;
        if (round_cnt >= flen || round_cnt == 0) begin
            divisor = (round_cnt == 0) ? 256 : round_cnt;
            for (int i = 0; i < n; i++) begin
                avg = slot_sums[i] / divisor;
                if (avg > adc_avg_pkg::CODE_MAX)
                    avg = adc_avg_pkg::CODE_MAX;
                mv = (64'(avg) * 64'(reg_rate)) >> 16;
                if (mv > 16'hFFFF)
                    mv = 16'hFFFF;
                add_result(adc_avg_pkg::KIND_AVG, i, avg, int'(mv), 1'b0);
            end
            for (int i = 0; i < NUM_SLOTS_MAX; i++)
                slot_sums[i] = '0;
            round_cnt = '0;
            if (pass_cnt != 8'hFF)
                pass_cnt = pass_cnt + 1'b1;
        end

        if (pass_cnt >= plim) begin
            scan_done = 1'b1;
            add_result(adc_avg_pkg::KIND_FINISH, 0, 0, 0, 1'b1);
        end else begin
            add_result(adc_avg_pkg::KIND_START, 0, 0, 0, 1'b1);
        end
    endfunction

    function automatic void report_field(input string name, input int want, input int got);
        errors++;
        $display("%0t mismatch on %s: expected %0d actual %0d", $time, name, want, got);
    endfunction

    function automatic void check_result();
        t_scan_result want;
        if (due_results.size() == 0) begin
            errors++;
            $display("%0t result with nothing pending: kind %0d slot %0d avg %0d mv %0d last %0d",
                     $time, res_bus.result_kind, res_bus.slot, res_bus.average_code,
                     res_bus.voltage_mv, res_bus.last);
            return;
        end
        want = due_results.pop_front();
        if (res_bus.result_kind !== want.kind)
            report_field("result_kind", want.kind, res_bus.result_kind);
        if (res_bus.slot !== want.slot)
            report_field("slot", want.slot, res_bus.slot);
        if (res_bus.average_code !== want.avg_code)
            report_field("average_code", want.avg_code, res_bus.average_code);
        if (res_bus.voltage_mv !== want.mv)
            report_field("voltage_mv", want.mv, res_bus.voltage_mv);
        if (res_bus.last !== want.last)
            report_field("last", want.last, res_bus.last);
    endfunction

    // sample driver: holds the code while stalled, predicts on each transfer
    always @(posedge i_clk) begin : sample_driver
        logic hold;
        if (!i_rst_n) begin
            smp_bus.valid           <= 1'b0;
            smp_bus.conversion_code <= '0;
        end else begin
            hold = smp_bus.valid && !smp_bus.ready;
            if (smp_bus.valid && smp_bus.ready) begin
                predict_scan_step(smp_bus.conversion_code);
                void'(sample_codes.pop_front());
            end
            if (!hold) begin
                if (sample_codes.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    smp_bus.valid           <= 1'b1;
                    smp_bus.conversion_code <= sample_codes[0];
                end else begin
                    smp_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready)
                check_result();
            res_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[adc_scan_averager] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx,
                             input logic [adc_avg_pkg::DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            adc_avg_pkg::REG_NUM_SLOTS:  reg_slots = value[adc_avg_pkg::NSL_W-1:0];
            adc_avg_pkg::REG_FILTER_LEN: reg_flen  = value[adc_avg_pkg::CNT8_W-1:0];
            adc_avg_pkg::REG_MV_RATE:    reg_rate  = value[adc_avg_pkg::RATE_W-1:0];
            adc_avg_pkg::REG_PASS_LIM:   reg_plim  = value[adc_avg_pkg::CNT8_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_scan(input int slots, input int flen, input int rate);
        write_reg(adc_avg_pkg::REG_NUM_SLOTS, slots);
        write_reg(adc_avg_pkg::REG_FILTER_LEN, flen);
        write_reg(adc_avg_pkg::REG_MV_RATE, rate);
    endtask

    task automatic random_config();
        int slots;
        int flen;
        slots = ($urandom_range(3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
        flen  = ($urandom_range(4) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 3);
        set_scan(slots, flen, $urandom_range(0, (1 << adc_avg_pkg::RATE_W) - 1));
        write_reg(adc_avg_pkg::REG_PASS_LIM, $urandom_range(200, 255));
    endtask

    // wait until every code is transferred and every result has come back
    task automatic drain();
        do @(negedge i_clk);
        while (sample_codes.size() != 0 || smp_bus.valid || due_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic push_random_codes(input int count);
        logic [adc_avg_pkg::CODE_W-1:0] code;
        repeat (count) begin
            if ($urandom_range(7) == 0)
                code = $urandom_range(1) ? adc_avg_pkg::CODE_MAX : '0;
            else
                code = $urandom_range(0, adc_avg_pkg::CODE_MAX);
            sample_codes.push_back(code);
        end
    endtask

    initial begin
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;

        reg_slots = adc_avg_pkg::RST_NUM_SLOTS;
        reg_flen  = adc_avg_pkg::RST_FILTER_LEN;
        reg_rate  = adc_avg_pkg::RST_MV_RATE;
        reg_plim  = adc_avg_pkg::RST_PASS_LIM;
        scan_slot = '0;
        round_cnt = '0;
        pass_cnt  = '0;
        scan_done = 1'b0;
        for (int i = 0; i < NUM_SLOTS_MAX; i++)
            slot_sums[i] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: one round over three slots, no pass yet
        sample_codes.push_back(adc_avg_pkg::CODE_MAX);
        sample_codes.push_back('0);
        sample_codes.push_back(12'h800);
        drain();

        // full-scale rate; pass ends with two rounds already counted
        set_scan(2, 1, (1 << adc_avg_pkg::RATE_W) - 1);
        sample_codes.push_back(adc_avg_pkg::CODE_MAX);
        sample_codes.push_back(adc_avg_pkg::CODE_MAX);
        drain();

        // zero slots behaves as one: every sample is a pass
        set_scan(0, 1, (1 << adc_avg_pkg::RATE_W) - 1);
        sample_codes.push_back(12'h555);
        sample_codes.push_back(12'hAAA);
        drain();

        // slot count above the table clamps to eight, filter length zero acts as one
        set_scan(15, 0, 0);
        for (int i = 0; i < 8; i++)
            sample_codes.push_back(i[0] ? 12'h000 : adc_avg_pkg::CODE_MAX);
        drain();

        // stop mid-scan at slot five, then shrink the table below it
        set_scan(8, 255, adc_avg_pkg::RST_MV_RATE);
        for (int i = 0; i < 5; i++)
            sample_codes.push_back(12'h123 << i);
        drain();
        set_scan(2, 255, adc_avg_pkg::RST_MV_RATE);
        sample_codes.push_back(12'h7FF);
        drain();

        // lowering the filter length mid-pass divides by the rounds counted
        set_scan(1, 1, 1 << 16);
        sample_codes.push_back(12'hC3C);
        drain();

        write_reg(adc_avg_pkg::REG_PASS_LIM, 255);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 75; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 75; end
                default: begin src_idle_pct = 18; snk_stall_pct = 18; end
            endcase
            for (int blk = 0; blk < 2; blk++) begin
                random_config();
                push_random_codes($urandom_range(8, 14));
                drain();
            end
        end

        // a passes limit of zero counts as one: the next round end stops the scan,
        // and the samples after it are taken and dropped
        set_scan(2, 1, adc_avg_pkg::RST_MV_RATE);
        write_reg(adc_avg_pkg::REG_PASS_LIM, 0);
        push_random_codes(6);
        drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && due_results.size() == 0)
            $display("[adc_scan_averager] OK");
        else
            $display("[adc_scan_averager] ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/adc_avg_pkg.sv
hw/rtl/adc_avg_if.sv
hw/rtl/adc_avg_div.sv
hw/rtl/adc_scan_averager.sv
verif/adc_scan_averager_tb.sv
